>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation sees real checks;
// synthesis sees empty macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ant, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)

`endif

`endif

>>> rtl/rfb_pkg.sv
`timescale 1ns / 1ps

package rfb_pkg;

    localparam int unsigned SCREEN_WIDTH  = 480;
    localparam int unsigned SCREEN_HEIGHT = 272;

    localparam int unsigned ADDR_W  = 17;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned PROD_W  = 18;

    typedef enum logic [MODE_W-1:0] {
        MODE_FILL  = 2'd0,
        MODE_COPY  = 2'd1,
        MODE_KEYED = 2'd2
    } mode_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_FILL_COLOR  = 3'd1,
        REG_KEY_COLOR   = 3'd2,
        REG_ORIGIN_X    = 3'd3,
        REG_ORIGIN_Y    = 3'd4,
        REG_RECT_WIDTH  = 3'd5,
        REG_RECT_HEIGHT = 3'd6
    } reg_idx_t;

    typedef struct packed {
        mode_t              mode;
        logic [PIX_W-1:0]   fill_color;
        logic [PIX_W-1:0]   key_color;
        logic [CNT_W-1:0]   rect_width;
        logic [CNT_W-1:0]   rect_height;
        logic [ADDR_W-1:0]  origin_addr;
        logic               oob;
    } cfg_t;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [PIX_W-1:0]   write_data;
        logic               last;
        logic               out_of_bounds;
    } result_t;

endpackage

>>> rtl/rect_fill_blit_color_key.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// pixel in  in         in_valid/in_stall    source_pixel, restart
// write out out        out_valid/out_stall  write_enable, write_address,
//                                           write_data, last, out_of_bounds
//
// A new pixel transfer is taken every cycle while in_stall is low. The
// result appears in the output register in the cycle after its input transfer.
// Reset (rst_n low, asynchronous) clears registers, position and output valid.
// in_stall is high only while a result is held and out_stall is high.

module rect_fill_blit_color_key
    import rfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [PIX_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PIX_W-1:0]    source_pixel,
    input  logic                restart,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                write_enable,
    output logic [ADDR_W-1:0]   write_address,
    output logic [PIX_W-1:0]    write_data,
    output logic                last,
    output logic                out_of_bounds
);

`include "assert_macros.svh"

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    // Registers are always writable; software must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    rfb_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The output register parts the two sides: a held result stalls the input
    // only when the downstream side is also stalling.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    rfb_walk u_walk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .advance      (accept),
        .source_pixel (source_pixel),
        .restart      (restart),
        .result       (result)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = result_reg.write_enable;
    assign write_address = result_reg.write_address;
    assign write_data    = result_reg.write_data;
    assign last          = result_reg.last;
    assign out_of_bounds = result_reg.out_of_bounds;

    // A write is never issued for a rectangle that leaves the screen.
    `ASSERT_IMPLIES(a_no_oob_write, clk, rst_n, out_valid && write_enable, !out_of_bounds, "write issued while out of bounds")
    // Without a write, address and data read as zero.
    `ASSERT_IMPLIES(a_idle_zero, clk, rst_n, out_valid && !write_enable, (write_address == '0) && (write_data == '0), "nonzero address or data without write")
    // Every accepted pixel shows up in the output register on the next cycle.
    `ASSERT_NEXT(a_accept_out, clk, rst_n, in_valid && !in_stall, out_valid, "accepted pixel produced no result")
    // A result held under downstream stall must block new input.
    `ASSERT_IMPLIES(a_backpressure, clk, rst_n, out_valid && out_stall, in_stall, "input not stalled while result held")

endmodule

>>> rtl/rfb_cfg.sv
`timescale 1ns / 1ps

module rfb_cfg
    import rfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [INDEX_W-1:0]  wr_index,
    input  logic [PIX_W-1:0]    wr_data,
    output cfg_t                cfg
);

    mode_t             mode_reg;
    logic [PIX_W-1:0]  fill_color_reg;
    logic [PIX_W-1:0]  key_color_reg;
    logic [CNT_W-1:0]  origin_x_reg;
    logic [CNT_W-1:0]  origin_y_reg;
    logic [CNT_W-1:0]  rect_width_reg;
    logic [CNT_W-1:0]  rect_height_reg;

    logic [CNT_W:0]    x_end;
    logic [CNT_W:0]    y_end;
    logic [PROD_W-1:0] origin_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FILL;
            fill_color_reg  <= '0;
            key_color_reg   <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_MODE:        mode_reg        <= mode_t'(wr_data[MODE_W-1:0]);
                REG_FILL_COLOR:  fill_color_reg  <= wr_data;
                REG_KEY_COLOR:   key_color_reg   <= wr_data;
                REG_ORIGIN_X:    origin_x_reg    <= wr_data[CNT_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= wr_data[CNT_W-1:0];
                REG_RECT_WIDTH:  rect_width_reg  <= wr_data[CNT_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= wr_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Bounds check and the frame buffer index of the top left corner.
    assign x_end = {1'b0, origin_x_reg} + {1'b0, rect_width_reg};
    assign y_end = {1'b0, origin_y_reg} + {1'b0, rect_height_reg};
    assign origin_prod = PROD_W'(origin_y_reg) * PROD_W'(SCREEN_WIDTH)
                       + PROD_W'(origin_x_reg);

    always_comb
    begin
        cfg.mode        = mode_reg;
        cfg.fill_color  = fill_color_reg;
        cfg.key_color   = key_color_reg;
        cfg.rect_width  = rect_width_reg;
        cfg.rect_height = rect_height_reg;
        cfg.origin_addr = origin_prod[ADDR_W-1:0];
        cfg.oob         = (x_end > (CNT_W+1)'(SCREEN_WIDTH))
                       || (y_end > (CNT_W+1)'(SCREEN_HEIGHT));
    end

endmodule

>>> rtl/rfb_walk.sv
`timescale 1ns / 1ps

module rfb_walk
    import rfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              advance,
    input  logic [PIX_W-1:0]  source_pixel,
    input  logic              restart,
    output result_t           result
);

    logic [CNT_W-1:0]  column_count_reg, column_count_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;

    logic [CNT_W-1:0]  col_eff;
    logic [CNT_W-1:0]  row_eff;
    logic [ADDR_W-1:0] base_eff;
    logic              empty;
    logic              row_end;
    logic              last_row;
    logic              last;
    logic              we;
    logic [PIX_W-1:0]  pix;

    // A restart moves the position to the origin before this pixel is used.
    assign col_eff  = restart ? '0 : column_count_reg;
    assign row_eff  = restart ? '0 : row_count_reg;
    assign base_eff = restart ? cfg.origin_addr : row_base_reg;

    assign empty    = (cfg.rect_width == '0) || (cfg.rect_height == '0);
    assign row_end  = ({1'b0, col_eff} + 1'b1) >= {1'b0, cfg.rect_width};
    assign last_row = ({1'b0, row_eff} + 1'b1) >= {1'b0, cfg.rect_height};
    assign last     = empty || (row_end && last_row);

    always_comb
    begin
        we  = 1'b0;
        pix = '0;
        unique case (cfg.mode)
            MODE_FILL:
            begin
                we  = 1'b1;
                pix = cfg.fill_color;
            end
            MODE_COPY:
            begin
                we  = 1'b1;
                pix = source_pixel;
            end
            MODE_KEYED:
            begin
                we  = (source_pixel != cfg.key_color);
                pix = {source_pixel[7:0], source_pixel[15:8]};
            end
            default:
            begin
                we  = 1'b0;
                pix = '0;
            end
        endcase
        if (empty || cfg.oob)
        begin
            we = 1'b0;
        end

        result.write_enable  = we;
        result.write_address = we ? (base_eff + ADDR_W'(col_eff)) : '0;
        result.write_data    = we ? pix : '0;
        result.last          = last;
        result.out_of_bounds = cfg.oob;
    end

    always_comb
    begin
        priority if (last)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            row_base_next     = cfg.origin_addr;
        end
        else if (row_end)
        begin
            column_count_next = '0;
            row_count_next    = row_eff + 1'b1;
            row_base_next     = base_eff + ADDR_W'(SCREEN_WIDTH);
        end
        else
        begin
            column_count_next = col_eff + 1'b1;
            row_count_next    = row_eff;
            row_base_next     = base_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            row_base_reg     <= '0;
        end
        else if (advance)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            row_base_reg     <= row_base_next;
        end
    end

endmodule
